// File: hw/rtl/rsmb_pkg.sv
// Shared types and constants for the mirrored run-length sprite blitter.
// Used by rsmb_front, rsmb_back, the top level and the testbench; depends on nothing.
`default_nettype none

package rsmb_pkg;

    localparam int ADDR_BITS_DEFAULT   = 24;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int PALETTE_DEPTH       = 256;
    localparam int COLOR_W             = 16;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 16;
    localparam int OUT_ADDR_W          = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_CODE   = 3'd4;

    localparam logic [7:0] EFFECT_MIN_RESET = 8'd224;
    localparam logic [7:0] RUN_CODE_RESET   = 8'd248;

    localparam logic [1:0] KIND_COLOR  = 2'd0;
    localparam logic [1:0] KIND_EFFECT = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    typedef enum logic [2:0] {
        CMD_PAL    = 3'd0,
        CMD_PIXEL  = 3'd1,
        CMD_EFFECT = 3'd2,
        CMD_RUN    = 3'd3,
        CMD_SKIP   = 3'd4
    } cmd_t;

    typedef struct packed {
        cmd_t        kind;
        logic [7:0]  data_byte;
        logic [7:0]  pal_index;
        logic [15:0] pal_color;
    } entry_t;

    typedef struct packed {
        logic [15:0] stride;
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        logic [7:0]  effect_min;
        logic [7:0]  run_code;
    } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/rsmb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the palette store.
`default_nettype none

module rsmb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/rsmb_fifo.sv
// Small register queue between the front decoder and the back executor.
// Self-contained; the entry width is set by the instantiating module.
`default_nettype none

module rsmb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] din,
    input  wire logic             pop,
    output logic                  empty,
    output logic      [WIDTH-1:0] dout
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push_ok, pop_ok;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rsmb_front.sv
// Front end: configuration registers and classification of incoming items.
// Depends on rsmb_pkg for the entry, configuration and command types.
`default_nettype none

module rsmb_front
    import rsmb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  operation,
    input  wire logic [7:0]            stream_byte,
    input  wire logic [7:0]            palette_index,
    input  wire logic [15:0]           palette_color,
    output entry_t                     entry,
    output cfg_t                       cfg
);

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROW_STRIDE: cfg_next.stride     = cfg_data;
                REG_DEST_X:     cfg_next.dest_x     = cfg_data;
                REG_DEST_Y:     cfg_next.dest_y     = cfg_data;
                REG_EFFECT_MIN: cfg_next.effect_min = cfg_data[7:0];
                REG_RUN_CODE:   cfg_next.run_code   = cfg_data[7:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stride     <= '0;
            cfg_reg.dest_x     <= '0;
            cfg_reg.dest_y     <= '0;
            cfg_reg.effect_min <= EFFECT_MIN_RESET;
            cfg_reg.run_code   <= RUN_CODE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Code classes are tested in order: pixel, effect, run marker, skip.
    always_comb
    begin
        entry.data_byte = stream_byte;
        entry.pal_index = palette_index;
        entry.pal_color = palette_color;
        if (operation)
        begin
            entry.kind = CMD_PAL;
        end
        else if (stream_byte < cfg_reg.effect_min)
        begin
            entry.kind = CMD_PIXEL;
        end
        else if (stream_byte < cfg_reg.run_code)
        begin
            entry.kind = CMD_EFFECT;
        end
        else if (stream_byte == cfg_reg.run_code)
        begin
            entry.kind = CMD_RUN;
        end
        else
        begin
            entry.kind = CMD_SKIP;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rsmb_back.sv
// Back end: header parsing, position tracking, skips, palette lookup and result slot.
// Depends on rsmb_pkg and instantiates rsmb_ram for the palette.
`default_nettype none

module rsmb_back
    import rsmb_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_t                  cfg,
    input  wire logic                  q_empty,
    input  wire entry_t                q_data,
    output logic                       q_pop,
    input  wire logic                  pop,
    output logic                       empty,
    output logic [1:0]                 pixel_kind,
    output logic [OUT_ADDR_W-1:0]      pixel_address,
    output logic [COLOR_W-1:0]         pixel_color,
    output logic [7:0]                 effect_code,
    output logic                       image_done
);

    localparam logic [2:0] HDR_LEN = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_BASE = 4'b0010,
        S_SKIP = 4'b0100,
        S_PIX  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [2:0]             hdr_cnt_reg, hdr_cnt_next;
    logic [15:0]            width_reg, width_next;
    logic [15:0]            height_reg, height_next;
    logic [15:0]            row_reg, row_next;
    logic [15:0]            col_reg, col_next;
    logic [ADDR_BITS-1:0]   base_reg, base_next;
    logic                   await_reg, await_next;
    logic [8:0]             skip_reg, skip_next;
    logic [31:0]            prod_reg, prod_next;
    logic [15:0]            dx_reg, dx_next;

    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_kind_reg, out_kind_next;
    logic [OUT_ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [COLOR_W-1:0]     out_color_reg, out_color_next;
    logic [7:0]             out_eff_reg, out_eff_next;
    logic                   out_done_reg, out_done_next;

    logic                   ram_we;
    logic [COLOR_W-1:0]     ram_rdata;
    logic [7:0]             b;
    logic [16:0]            adv_row;
    logic                   row_end;
    logic                   adv_fin;
    logic [ADDR_BITS-1:0]   pix_sum;
    logic [31:0]            pix_wide;
    logic [16:0]            skip_rem;

    rsmb_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_data.pal_index),
        .wdata (q_data.pal_color),
        .raddr (q_data.data_byte),
        .rdata (ram_rdata)
    );

    assign b        = q_data.data_byte;
    assign adv_row  = {1'b0, row_reg} + 17'd1;
    assign row_end  = (adv_row >= {1'b0, height_reg});
    assign adv_fin  = (col_reg == '0) && row_end;
    assign pix_sum  = base_reg + ADDR_BITS'(col_reg);
    assign pix_wide = 32'(pix_sum);
    assign skip_rem = {8'd0, skip_reg} - ({1'b0, col_reg} + 17'd1);

    assign empty         = !out_valid_reg;
    assign pixel_kind    = out_kind_reg;
    assign pixel_address = out_addr_reg;
    assign pixel_color   = out_color_reg;
    assign effect_code   = out_eff_reg;
    assign image_done    = out_done_reg;

    always_comb
    begin
        state_next     = state_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        await_next     = await_reg;
        skip_next      = skip_reg;
        prod_next      = prod_reg;
        dx_next        = dx_reg;
        out_valid_next = out_valid_reg && !pop;
        out_kind_next  = out_kind_reg;
        out_addr_next  = out_addr_reg;
        out_color_next = out_color_reg;
        out_eff_next   = out_eff_reg;
        out_done_next  = out_done_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                // A command is taken only while the result slot is empty, so any
                // result it causes later always finds the slot free.
                if (!q_empty && !out_valid_reg)
                begin
                    q_pop = 1'b1;
                    if (q_data.kind == CMD_PAL)
                    begin
                        ram_we = 1'b1;
                    end
                    else if (hdr_cnt_reg != HDR_LEN)
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                        case (hdr_cnt_reg[1:0])
                            2'd0:    width_next        = {8'd0, b};
                            2'd1:    width_next[15:8]  = b;
                            2'd2:    height_next       = {8'd0, b};
                            default: height_next[15:8] = b;
                        endcase
                        if (hdr_cnt_reg[1:0] == 2'd3)
                        begin
                            await_next = 1'b0;
                            skip_next  = '0;
                            if (width_reg == '0 || {b, height_reg[7:0]} == '0)
                            begin
                                hdr_cnt_next   = '0;
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_DONE;
                                out_addr_next  = '0;
                                out_color_next = '0;
                                out_eff_next   = '0;
                                out_done_next  = 1'b1;
                            end
                            else
                            begin
                                row_next   = '0;
                                col_next   = width_reg - 16'd1;
                                prod_next  = {16'd0, cfg.dest_y} * {16'd0, cfg.stride};
                                dx_next    = cfg.dest_x;
                                state_next = S_BASE;
                            end
                        end
                    end
                    else if (await_reg)
                    begin
                        await_next = 1'b0;
                        skip_next  = {1'b0, b};
                        if (b != '0)
                        begin
                            state_next = S_SKIP;
                        end
                    end
                    else
                    begin
                        case (q_data.kind)
                            CMD_PIXEL, CMD_EFFECT:
                            begin
                                out_kind_next = (q_data.kind == CMD_PIXEL) ? KIND_COLOR
                                                                           : KIND_EFFECT;
                                out_addr_next  = pix_wide[OUT_ADDR_W-1:0];
                                out_color_next = '0;
                                out_eff_next   = (q_data.kind == CMD_PIXEL) ? 8'd0 : b;
                                out_done_next  = adv_fin;
                                if (q_data.kind == CMD_PIXEL)
                                begin
                                    state_next = S_PIX;
                                end
                                else
                                begin
                                    out_valid_next = 1'b1;
                                end
                                if (col_reg != '0)
                                begin
                                    col_next = col_reg - 16'd1;
                                end
                                else if (row_end)
                                begin
                                    hdr_cnt_next = '0;
                                    await_next   = 1'b0;
                                end
                                else
                                begin
                                    row_next  = adv_row[15:0];
                                    col_next  = width_reg - 16'd1;
                                    base_next = base_reg + ADDR_BITS'(cfg.stride);
                                end
                            end
                            CMD_RUN:
                            begin
                                await_next = 1'b1;
                            end
                            default:
                            begin
                                skip_next  = 9'd256 - {1'b0, b};
                                state_next = S_SKIP;
                            end
                        endcase
                    end
                end
            end
            S_BASE:
            begin
                base_next  = ADDR_BITS'(prod_reg + {16'd0, dx_reg});
                state_next = S_IDLE;
            end
            S_SKIP:
            begin
                // Skips inside the current row finish at once; otherwise each row crossed
                // is stepped over in turn in this state.
                if ({7'd0, skip_reg} <= col_reg)
                begin
                    col_next   = col_reg - {7'd0, skip_reg};
                    skip_next  = '0;
                    state_next = S_IDLE;
                end
                else if (row_end)
                begin
                    hdr_cnt_next   = '0;
                    await_next     = 1'b0;
                    skip_next      = '0;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_DONE;
                    out_addr_next  = '0;
                    out_color_next = '0;
                    out_eff_next   = '0;
                    out_done_next  = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    row_next  = adv_row[15:0];
                    col_next  = width_reg - 16'd1;
                    base_next = base_reg + ADDR_BITS'(cfg.stride);
                    skip_next = skip_rem[8:0];
                    if (skip_rem == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_PIX:
            begin
                out_color_next = ram_rdata;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hdr_cnt_reg   <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            await_reg     <= 1'b0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            await_reg     <= await_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        dx_reg        <= dx_next;
        out_kind_reg  <= out_kind_next;
        out_addr_reg  <= out_addr_next;
        out_color_reg <= out_color_next;
        out_eff_reg   <= out_eff_next;
        out_done_reg  <= out_done_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/rle_sprite_mirror_blit_top.sv
// Top level of the mirrored run-length sprite blitter.
// Depends on rsmb_pkg and instantiates rsmb_front, rsmb_fifo and rsmb_back.
`default_nettype none

// The block takes palette writes and a compressed sprite stream through a queue-style
// input, and hands out one pixel write, effect request or completion item at a time
// through a queue-style output. A queue of QUEUE_DEPTH classified items separates the
// input side from the executor, so the input keeps taking items while a result waits
// until that queue is full. While no result waits, the executor takes one queued item
// per cycle for palette writes, header bytes, run markers and zero run lengths; an
// effect code is taken straight from the idle state. A pixel code passes through S_PIX
// for the palette memory read, and the last header byte of a non-empty sprite registers
// the start-address product and adds the X offset in S_BASE. A skip passes through
// S_SKIP, which steps over each sprite row boundary it crosses. An item that causes a
// result holds the executor until that result is popped, so the next item is taken in
// the cycle after the pop at the earliest. Configuration writes are taken every cycle.
module rle_sprite_mirror_blit_top
    import rsmb_pkg::*;
#(
    parameter int ADDR_BITS   = ADDR_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  operation,
    input  wire logic [7:0]            stream_byte,
    input  wire logic [7:0]            palette_index,
    input  wire logic [15:0]           palette_color,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [1:0]                 pixel_kind,
    output logic [OUT_ADDR_W-1:0]      pixel_address,
    output logic [COLOR_W-1:0]         pixel_color,
    output logic [7:0]                 effect_code,
    output logic                       image_done
);

    entry_t in_entry;
    entry_t q_data;
    cfg_t   cfg;
    logic   q_empty;
    logic   q_pop;

    rsmb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .stream_byte   (stream_byte),
        .palette_index (palette_index),
        .palette_color (palette_color),
        .entry         (in_entry),
        .cfg           (cfg)
    );

    rsmb_fifo #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .din   (in_entry),
        .pop   (q_pop),
        .empty (q_empty),
        .dout  (q_data)
    );

    rsmb_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .pixel_kind    (pixel_kind),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .effect_code   (effect_code),
        .image_done    (image_done)
    );

endmodule

`default_nettype wire

// File: dv/rle_sprite_mirror_blit_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for rle_sprite_mirror_blit_top: palette loads and compressed,
// mirrored sprite streams go in, predicted pixel writes, effect requests and completions
// are checked field by field. Depends on rsmb_pkg and the block's RTL.

module rle_sprite_mirror_blit_top_test;
    import rsmb_pkg::*;

    localparam logic                 OP_STREAM      = 1'b0;
    localparam logic                 OP_PALETTE     = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 3'd7;
    localparam logic [2:0]           HDR_BYTES      = 3'd4;
    localparam int                   SETTLE_CYCLES  = 1600;
    localparam int                   WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic [1:0]            kind;
        logic [OUT_ADDR_W-1:0] addr;
        logic [COLOR_W-1:0]    color;
        logic [7:0]            effect;
        logic                  done;
    } blit_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  push;
    logic                  full;
    logic                  operation;
    logic [7:0]            stream_byte;
    logic [7:0]            palette_index;
    logic [15:0]           palette_color;
    logic                  empty;
    logic                  pop;
    logic [1:0]            pixel_kind;
    logic [OUT_ADDR_W-1:0] pixel_address;
    logic [COLOR_W-1:0]    pixel_color;
    logic [7:0]            effect_code;
    logic                  image_done;

    rle_sprite_mirror_blit_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .stream_byte   (stream_byte),
        .palette_index (palette_index),
        .palette_color (palette_color),
        .empty         (empty),
        .pop           (pop),
        .pixel_kind    (pixel_kind),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .effect_code   (effect_code),
        .image_done    (image_done)
    );

    always #5 clk = ~clk;

    // Predicted block state and register copies.
    logic [15:0]           palette_copy [PALETTE_DEPTH];
    bit                    palette_set  [PALETTE_DEPTH];
    logic [2:0]            hdr_count;
    logic [15:0]           spr_width;
    logic [15:0]           spr_height;
    logic [15:0]           row_idx;
    logic [15:0]           col_idx;
    logic [OUT_ADDR_W-1:0] row_base;
    bit                    run_len_next;
    logic [15:0]           reg_stride;
    logic [15:0]           reg_dest_x;
    logic [15:0]           reg_dest_y;
    logic [7:0]            reg_effect_min;
    logic [7:0]            reg_run_code;

    blit_result_t pixel_writes_due [$];
    int unsigned  mismatch_count;
    int unsigned  items_sent;
    int unsigned  steady_items;
    bit           burst_mode;
    int unsigned  hold_results;
    int unsigned  pop_wait;
    int unsigned  pop_steady;
    int unsigned  quiet_cycles;

    function automatic void reset_blit_model();
        hdr_count      = '0;
        spr_width      = '0;
        spr_height     = '0;
        row_idx        = '0;
        col_idx        = '0;
        row_base       = '0;
        run_len_next   = 1'b0;
        reg_stride     = '0;
        reg_dest_x     = '0;
        reg_dest_y     = '0;
        reg_effect_min = EFFECT_MIN_RESET;
        reg_run_code   = RUN_CODE_RESET;
        foreach (palette_set[i])
            palette_set[i] = 1'b0;
    endfunction

    function automatic void add_expected(input logic [1:0] kind, input logic [OUT_ADDR_W-1:0] addr,
                                         input logic [15:0] color, input logic [7:0] effect,
                                         input logic done);
        blit_result_t r;
        r.kind   = kind;
        r.addr   = addr;
        r.color  = color;
        r.effect = effect;
        r.done   = done;
        pixel_writes_due.push_back(r);
    endfunction

    // Steps one position right to left, then down a row; returns 1 past the last position.
    function automatic bit next_position();
        if (col_idx == 16'd0)
        begin
            row_idx = row_idx + 16'd1;
            if (row_idx >= spr_height)
            begin
                hdr_count    = '0;
                run_len_next = 1'b0;
                return 1'b1;
            end
            col_idx  = spr_width - 16'd1;
            row_base = row_base + reg_stride;
        end
        else
            col_idx = col_idx - 16'd1;
        return 1'b0;
    endfunction

    function automatic bit skip_positions(input int unsigned count);
        bit fin;
        fin = 1'b0;
        while (count != 0 && !fin)
        begin
            count--;
            fin = next_position();
        end
        return fin;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ROW_STRIDE: reg_stride     = data;
            REG_DEST_X:     reg_dest_x     = data;
            REG_DEST_Y:     reg_dest_y     = data;
            REG_EFFECT_MIN: reg_effect_min = data[7:0];
            REG_RUN_CODE:   reg_run_code   = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_blit(input logic op, input logic [7:0] code,
                                         input logic [7:0] pidx, input logic [15:0] pcol);
        logic [31:0]           start_addr;
        logic [OUT_ADDR_W-1:0] addr;
        bit                    fin;
        if (op == OP_PALETTE)
        begin
            palette_copy[pidx] = pcol;
            palette_set[pidx]  = 1'b1;
            return;
        end
        if (hdr_count < HDR_BYTES)
        begin
            case (hdr_count)
                3'd0:    spr_width         = {8'd0, code};
                3'd1:    spr_width[15:8]   = code;
                3'd2:    spr_height        = {8'd0, code};
                default: spr_height[15:8]  = code;
            endcase
            hdr_count = hdr_count + 3'd1;
            if (hdr_count < HDR_BYTES)
                return;
            run_len_next = 1'b0;
            if (spr_width == 16'd0 || spr_height == 16'd0)
            begin
                hdr_count = '0;
                add_expected(KIND_DONE, '0, '0, '0, 1'b1);
                return;
            end
            row_idx    = '0;
            col_idx    = spr_width - 16'd1;
            start_addr = reg_dest_y * reg_stride + reg_dest_x;
            row_base   = start_addr[OUT_ADDR_W-1:0];
            return;
        end
        if (run_len_next)
        begin
            run_len_next = 1'b0;
            if (skip_positions(code))
                add_expected(KIND_DONE, '0, '0, '0, 1'b1);
            return;
        end
        if (code < reg_effect_min || code < reg_run_code)
        begin
            addr = row_base + col_idx;
            fin  = next_position();
            if (code < reg_effect_min)
                add_expected(KIND_COLOR, addr, palette_copy[code], '0, fin);
            else
                add_expected(KIND_EFFECT, addr, '0, code, fin);
            return;
        end
        if (code == reg_run_code)
        begin
            run_len_next = 1'b1;
            return;
        end
        if (skip_positions(256 - int'(code)))
            add_expected(KIND_DONE, '0, '0, '0, 1'b1);
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic void report_mismatch(input string what, input blit_result_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected kind %0d addr %h color %h effect %h done %b, %s",
                     $time, what, want.kind, want.addr, want.color, want.effect, want.done,
                     $sformatf("got kind %0d addr %h color %h effect %h done %b",
                               pixel_kind, pixel_address, pixel_color, effect_code,
                               image_done));
    endfunction

    // Called at a falling edge; returns at a falling edge with push possibly still high.
    task automatic send_item(input logic op, input logic [7:0] code, input logic [7:0] pidx,
                             input logic [15:0] pcol);
        int unsigned gap;
        push          <= 1'b1;
        operation     <= op;
        stream_byte   <= code;
        palette_index <= pidx;
        palette_color <= pcol;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_blit(op, code, pidx, pcol);
        items_sent++;
        @(negedge clk);
        if (burst_mode || steady_items != 0)
        begin
            gap = 0;
            if (steady_items != 0)
                steady_items--;
        end
        else
        begin
            gap = idle_gap();
            if ($urandom_range(0, 29) == 0)
                steady_items = $urandom_range(10, 40);
        end
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_palette(input logic [7:0] pidx, input logic [15:0] pcol);
        send_item(OP_PALETTE, 8'($urandom_range(0, 255)), pidx, pcol);
    endtask

    // A colour code must never read a palette entry that has not been loaded.
    task automatic send_stream(input logic [7:0] code);
        if (hdr_count == HDR_BYTES && !run_len_next && code < reg_effect_min &&
            !palette_set[code])
            send_palette(code, 16'($urandom_range(0, 65535)));
        send_item(OP_STREAM, code, 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)));
    endtask

    task automatic send_header(input logic [15:0] w, input logic [15:0] h);
        send_stream(w[7:0]);
        send_stream(w[15:8]);
        send_stream(h[7:0]);
        send_stream(h[15:8]);
    endtask

    // Ends whatever sprite is open with the fewest bytes, using skips and empty headers.
    task automatic finish_sprite();
        while (hdr_count != 0)
        begin
            if (hdr_count < HDR_BYTES)
                send_stream(8'd0);
            else if (run_len_next)
                send_stream(8'd255);
            else if (reg_run_code >= reg_effect_min)
                send_stream(reg_run_code);
            else
                send_stream(reg_effect_min);
        end
    endtask

    task automatic settle_block();
        push <= 1'b0;
        while (pixel_writes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_blit_config(input logic [15:0] stride, input logic [15:0] dx,
                                   input logic [15:0] dy, input logic [7:0] fx_min,
                                   input logic [7:0] run);
        logic [7:0] junk_hi;
        finish_sprite();
        settle_block();
        write_reg(REG_ROW_STRIDE, stride);
        write_reg(REG_DEST_X, dx);
        write_reg(REG_DEST_Y, dy);
        junk_hi = 8'($urandom_range(0, 255));
        write_reg(REG_EFFECT_MIN, {junk_hi, fx_min});
        junk_hi = 8'($urandom_range(0, 255));
        write_reg(REG_RUN_CODE, {junk_hi, run});
        write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
    endtask

    task automatic send_random_code();
        int unsigned pick;
        int unsigned lo;
        logic [7:0]  code;
        pick = $urandom_range(0, 99);
        if (run_len_next)
            code = (pick < 80) ? 8'($urandom_range(0, 12)) : 8'($urandom_range(0, 255));
        else if (pick < 50 && reg_effect_min != 0)
            code = 8'($urandom_range(0, reg_effect_min - 1));
        else if (pick < 70 && reg_run_code > reg_effect_min)
            code = 8'($urandom_range(reg_effect_min, reg_run_code - 1));
        else if (pick < 82 && reg_run_code >= reg_effect_min)
            code = reg_run_code;
        else
        begin
            lo = (reg_run_code >= reg_effect_min) ? reg_run_code + 1 : reg_effect_min;
            code = (lo <= 255) ? 8'($urandom_range(lo, 255)) : 8'($urandom_range(0, 255));
        end
        send_stream(code);
        if ($urandom_range(0, 19) == 0)
            send_palette(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic send_random_sprite();
        int unsigned shape;
        int unsigned codes;
        logic [15:0] w;
        logic [15:0] h;
        shape = $urandom_range(0, 19);
        if (shape == 0)
        begin
            // An empty sprite whose other dimension may be huge.
            if ($urandom_range(0, 1) == 0)
            begin
                w = 16'($urandom_range(0, 65535));
                h = '0;
            end
            else
            begin
                w = '0;
                h = 16'($urandom_range(0, 65535));
            end
        end
        else if (shape == 1)
        begin
            w = 16'($urandom_range(256, 400));
            h = 16'($urandom_range(1, 2));
        end
        else if (shape == 2)
        begin
            w = 16'd1;
            h = 16'($urandom_range(100, 300));
        end
        else
        begin
            w = 16'($urandom_range(1, 8));
            h = 16'($urandom_range(1, 6));
        end
        send_header(w, h);
        codes = 0;
        while (hdr_count == HDR_BYTES)
        begin
            if (codes >= 40)
                finish_sprite();
            else
                send_random_code();
            codes++;
        end
    endtask

    task automatic send_sprites(input int unsigned count);
        int unsigned stop;
        stop = items_sent + count;
        while (items_sent < stop)
            send_random_sprite();
    endtask

    task automatic test_directed_codes();
        send_palette(8'd0, 16'h0000);
        send_palette(EFFECT_MIN_RESET - 8'd1, 16'hFFFF);
        send_palette(8'd255, 16'h5A5A);
        send_header(16'd3, 16'd2);
        send_stream(8'd0);
        send_stream(EFFECT_MIN_RESET - 8'd1);
        send_stream(EFFECT_MIN_RESET);
        send_stream(RUN_CODE_RESET - 8'd1);
        send_stream(RUN_CODE_RESET);
        send_stream(8'd0);
        send_stream(8'd255);
        send_stream(RUN_CODE_RESET);
        send_stream(8'd255);
        send_header(16'd0, 16'd7);
        send_header(16'd1, 16'd1);
        send_stream(8'd0);
    endtask

    // The result side holds off while the stream keeps coming, so the block backs up.
    task automatic test_result_backpressure();
        int unsigned n;
        send_header(16'd8, 16'd6);
        hold_results = 400;
        burst_mode   = 1'b1;
        for (n = 0; n < 40 && hdr_count == HDR_BYTES; n++)
            send_stream(8'($urandom_range(0, reg_effect_min - 1)));
        burst_mode = 1'b0;
        finish_sprite();
    endtask

    task automatic test_register_extremes();
        set_blit_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_sprites(25);
        set_blit_config(16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_sprites(25);
        set_blit_config(16'h0001, 16'hFFFF, 16'h0000, 8'h00, 8'hFF);
        send_sprites(25);
        set_blit_config(16'd640, 16'd100, 16'd200, 8'd200, 8'd100);
        send_sprites(25);
        set_blit_config(16'hFFFF, 16'h0000, 16'hFFFF, EFFECT_MIN_RESET, RUN_CODE_RESET);
        send_sprites(25);
    endtask

    task automatic test_random_sprites();
        int unsigned n;
        logic [7:0]  fx_min;
        for (n = 0; n < 3; n++)
        begin
            fx_min = 8'($urandom_range(0, 255));
            set_blit_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), fx_min,
                            ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(fx_min, 255)));
            send_sprites(25);
        end
    endtask

    task automatic test_stream_noise();
        int unsigned stop;
        stop = items_sent + 60;
        while (items_sent < stop)
        begin
            if (hdr_count < HDR_BYTES)
                send_stream((hdr_count == 3'd0 || hdr_count == 3'd2)
                            ? 8'($urandom_range(0, 9)) : 8'd0);
            else if ($urandom_range(0, 9) == 0)
                send_palette(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            else
                send_stream(8'($urandom_range(0, 255)));
        end
        finish_sprite();
    endtask

    always @(negedge clk)
    begin
        if (hold_results != 0)
        begin
            pop_wait     = hold_results;
            hold_results = 0;
        end
        if (pop_wait != 0)
        begin
            pop <= 1'b0;
            pop_wait--;
        end
        else
        begin
            pop <= 1'b1;
            if (pop_steady != 0)
                pop_steady--;
            else if ($urandom_range(0, 4) == 0)
                pop_steady = $urandom_range(10, 60);
            else
                pop_wait = idle_gap();
        end
    end

    always @(posedge clk)
    begin
        blit_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pixel_writes_due.size() == 0)
            begin
                want = '{default: '0};
                report_mismatch("unexpected result", want);
            end
            else
            begin
                want = pixel_writes_due.pop_front();
                if (pixel_kind !== want.kind || pixel_address !== want.addr ||
                    pixel_color !== want.color || effect_code !== want.effect ||
                    image_done !== want.done)
                    report_mismatch("result mismatch", want);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rle_sprite_mirror_blit_top_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        operation      = OP_STREAM;
        stream_byte    = '0;
        palette_index  = '0;
        palette_color  = '0;
        mismatch_count = 0;
        items_sent     = 0;
        steady_items   = 0;
        burst_mode     = 1'b0;
        hold_results   = 0;
        pop_wait       = 0;
        pop_steady     = 0;
        quiet_cycles   = 0;
        reset_blit_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_codes();
        test_result_backpressure();
        test_register_extremes();
        test_random_sprites();
        test_stream_noise();
        settle_block();
        if (mismatch_count == 0 && pixel_writes_due.size() == 0)
            $display("rle_sprite_mirror_blit_top_test: PASS");
        else
            $display("rle_sprite_mirror_blit_top_test: FAIL");
        $finish;
    end

endmodule
